@@ src/swup_pkg.sv @@
`timescale 1ns / 1ps
// swup_pkg: shared types, codes and unit-word tables for the size-with-unit parser.
// Depends on nothing; used by swup_trie, swup_scale and size_with_unit_parser_unit.
package swup_pkg;

   // multiplier constants: 10^9 needs 30 bits
   localparam int UNIT_MULT_BITS = 30;
   localparam logic [UNIT_MULT_BITS-1:0] MULT_BYTE = 30'd1;
   localparam logic [UNIT_MULT_BITS-1:0] MULT_KILO = 30'd1000;
   localparam logic [UNIT_MULT_BITS-1:0] MULT_MEGA = 30'd1000000;
   localparam logic [UNIT_MULT_BITS-1:0] MULT_GIGA = 30'd1000000000;

   // unit families
   localparam logic [1:0] FAM_BYTE = 2'd0;
   localparam logic [1:0] FAM_KILO = 2'd1;
   localparam logic [1:0] FAM_MEGA = 2'd2;
   localparam logic [1:0] FAM_GIGA = 2'd3;

   // result status codes
   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_UNKNOWN  = 2'd1;
   localparam logic [1:0] ST_OVERFLOW = 2'd2;

   // characters
   localparam logic [7:0] CH_ZERO = "0";
   localparam logic [7:0] CH_NINE = "9";
   localparam logic [7:0] CH_LO_B = "b";
   localparam logic [7:0] CH_UP_B = "B";
   localparam logic [7:0] CASE_MASK = 8'hDF;

   // suffix matcher position: family, case of the first letter, which path
   // (short abbreviation or long spelled word) and characters consumed
   typedef struct packed {
      logic       dead;
      logic [1:0] fam;
      logic       lower;
      logic       long_path;
      logic [3:0] len;
   } trie_node_type;

   localparam trie_node_type TRIE_ROOT = '{dead: 1'b0, fam: 2'd0, lower: 1'b0,
                                           long_path: 1'b0, len: 4'd0};
   localparam trie_node_type TRIE_DEAD = '{dead: 1'b1, fam: 2'd0, lower: 1'b0,
                                           long_path: 1'b0, len: 4'd0};

   // verdict on the suffix seen so far
   typedef struct packed {
      logic       known;
      logic [1:0] fam;
   } unit_match_type;

   // control carried with one number through the scaling pipeline
   typedef struct packed {
      logic       known;
      logic [1:0] fam;
      logic       overflowed;
   } scale_ctl_type;

   function automatic logic [UNIT_MULT_BITS-1:0] unit_mult(input logic [1:0] fam);
      logic [UNIT_MULT_BITS-1:0] m;
      unique case (fam)
         FAM_BYTE: m = MULT_BYTE;
         FAM_KILO: m = MULT_KILO;
         FAM_MEGA: m = MULT_MEGA;
         default:  m = MULT_GIGA;
      endcase
      return m;
   endfunction

   // lowercase spelled word of each family, first character in the top byte
   function automatic logic [63:0] unit_word(input logic [1:0] fam);
      logic [63:0] w;
      unique case (fam)
         FAM_BYTE: w = {"byte", 32'h0};
         FAM_KILO: w = "kilobyte";
         FAM_MEGA: w = "megabyte";
         default:  w = "gigabyte";
      endcase
      return w;
   endfunction

   function automatic logic [7:0] unit_char(input logic [1:0] fam, input logic [2:0] idx);
      logic [63:0] w;
      w = unit_word(fam);
      return w[63 - 8*idx -: 8];
   endfunction

   function automatic logic [3:0] unit_len(input logic [1:0] fam);
      return (fam == FAM_BYTE) ? 4'd4 : 4'd8;
   endfunction

endpackage

@@ src/swup_trie.sv @@
`timescale 1ns / 1ps
// swup_trie: next-position and match logic of the unit suffix matcher.
// Depends on swup_pkg; the position register lives in the top level.
module swup_trie (
   input  swup_pkg::trie_node_type  node,
   input  logic [7:0]               ch,
   output swup_pkg::trie_node_type  node_next,
   output swup_pkg::unit_match_type match
);
   import swup_pkg::*;

   // advance on one suffix character
   always_comb begin
      node_next = node;
      priority if (node.dead) begin
         node_next = TRIE_DEAD;
      end else if (node.len == 4'd0) begin
         node_next = TRIE_DEAD;
         for (int f = 0; f < 4; f++) begin
            if (ch == unit_char(2'(f), 3'd0) ||
                ch == (unit_char(2'(f), 3'd0) & CASE_MASK)) begin
               node_next.dead      = 1'b0;
               node_next.fam       = 2'(f);
               node_next.lower     = (ch == unit_char(2'(f), 3'd0));
               node_next.long_path = 1'b0;
               node_next.len       = 4'd1;
            end
         end
      end else if (node.len == 4'd1) begin
         if (ch == unit_char(node.fam, 3'd1)) begin
            node_next.long_path = 1'b1;
            node_next.len       = 4'd2;
         end else if (node.fam != FAM_BYTE && ch == (node.lower ? CH_LO_B : CH_UP_B)) begin
            node_next.long_path = 1'b0;
            node_next.len       = 4'd2;
         end else begin
            node_next = TRIE_DEAD;
         end
      end else if (node.long_path && node.len < unit_len(node.fam) &&
                   ch == unit_char(node.fam, node.len[2:0])) begin
         node_next.len = node.len + 4'd1;
      end else begin
         node_next = TRIE_DEAD;
      end
   end

   // whole words: empty, single letter (not a capital B), abbreviation, full spelling
   always_comb begin
      match.known = !node.dead &&
                    (node.len == 4'd0 ||
                     (node.len == 4'd1 && (node.fam != FAM_BYTE || node.lower)) ||
                     (node.len == 4'd2 && !node.long_path) ||
                     (node.long_path && node.len == unit_len(node.fam)));
      match.fam   = (node.len == 4'd0) ? FAM_BYTE : node.fam;
   end

endmodule

@@ src/swup_scale.sv @@
`timescale 1ns / 1ps
// swup_scale: three-stage pipeline that multiplies the parsed number by the unit
// and forms the status. Depends on swup_pkg.
module swup_scale #(
   parameter int VALUE_BITS = 63
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   output logic                    in_ready,
   input  logic [VALUE_BITS-1:0]   in_acc,
   input  swup_pkg::scale_ctl_type in_ctl,
   output logic                    out_valid,
   input  logic                    out_stall,
   output logic [VALUE_BITS-1:0]   out_value,
   output logic [1:0]              out_status
);
   import swup_pkg::*;

   localparam int HALF_BITS = 32;
   localparam int PP_BITS   = HALF_BITS + UNIT_MULT_BITS;
   localparam int SUM_BITS  = PP_BITS + HALF_BITS;

   logic                      s1_v_ff, s1_v_in;
   logic [VALUE_BITS-1:0]     s1_acc_ff;
   scale_ctl_type             s1_ctl_ff;
   logic                      s2_v_ff, s2_v_in;
   logic [PP_BITS-1:0]        s2_lo_ff, s2_lo_in;
   logic [PP_BITS-1:0]        s2_hi_ff, s2_hi_in;
   scale_ctl_type             s2_ctl_ff;
   logic                      out_v_ff, out_v_in;
   logic [VALUE_BITS-1:0]     out_value_ff, out_value_in;
   logic [1:0]                out_status_ff, out_status_in;

   logic                      out_ready, s2_ready, s1_ready;
   logic [2*HALF_BITS-1:0]    acc_wide;
   logic [UNIT_MULT_BITS-1:0] mult;
   logic [SUM_BITS-1:0]       product;
   logic                      prod_ovf;

   // each stage moves when it is empty or its successor moves
   assign out_ready = !out_v_ff || !out_stall;
   assign s2_ready  = !s2_v_ff || out_ready;
   assign s1_ready  = !s1_v_ff || s2_ready;
   assign in_ready  = s1_ready;

   assign s1_v_in  = s1_ready ? in_valid : s1_v_ff;
   assign s2_v_in  = s2_ready ? s1_v_ff  : s2_v_ff;
   assign out_v_in = out_ready ? s2_v_ff : out_v_ff;

   // split the number into two halves and multiply each by the unit
   assign acc_wide = (2*HALF_BITS)'(s1_acc_ff);
   assign mult     = unit_mult(s1_ctl_ff.fam);
   assign s2_lo_in = acc_wide[HALF_BITS-1:0] * mult;
   assign s2_hi_in = acc_wide[2*HALF_BITS-1:HALF_BITS] * mult;

   // join the partial products and check the range
   assign product  = {s2_hi_ff, {HALF_BITS{1'b0}}} + SUM_BITS'(s2_lo_ff);
   assign prod_ovf = |product[SUM_BITS-1:VALUE_BITS];

   // unknown suffix outranks overflow; value stays zero unless ok
   always_comb begin
      out_value_in = '0;
      priority if (!s2_ctl_ff.known) begin
         out_status_in = ST_UNKNOWN;
      end else if (s2_ctl_ff.overflowed || prod_ovf) begin
         out_status_in = ST_OVERFLOW;
      end else begin
         out_status_in = ST_OK;
         out_value_in  = product[VALUE_BITS-1:0];
      end
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff  <= 1'b0;
         s2_v_ff  <= 1'b0;
         out_v_ff <= 1'b0;
      end else begin
         s1_v_ff  <= s1_v_in;
         s2_v_ff  <= s2_v_in;
         out_v_ff <= out_v_in;
      end
   end

   // payload, held while the stage cannot move
   always_ff @(posedge clock) begin
      if (s1_ready) begin
         s1_acc_ff <= in_acc;
         s1_ctl_ff <= in_ctl;
      end
      if (s2_ready) begin
         s2_lo_ff  <= s2_lo_in;
         s2_hi_ff  <= s2_hi_in;
         s2_ctl_ff <= s1_ctl_ff;
      end
      if (out_ready) begin
         out_value_ff  <= out_value_in;
         out_status_ff <= out_status_in;
      end
   end

   assign out_valid  = out_v_ff;
   assign out_value  = out_value_ff;
   assign out_status = out_status_ff;

   // a full pipeline behind a stalled output takes no new word
   a_full_blocks: assert property (@(posedge clock) disable iff (reset)
      (s1_v_ff && s2_v_ff && out_v_ff && out_stall) |-> !in_ready)
      else $error("scale pipeline accepted a word while full");

   // a known suffix whose product does not fit must report overflow
   a_prod_ovf: assert property (@(posedge clock) disable iff (reset)
      (s2_v_ff && out_ready && s2_ctl_ff.known && prod_ovf) |=>
      (out_status_ff == ST_OVERFLOW))
      else $error("product overflow not reported");

   // a taken result with nothing behind it leaves the output empty
   a_drain: assert property (@(posedge clock) disable iff (reset)
      (out_v_ff && !out_stall && !s2_v_ff) |=> !out_v_ff)
      else $error("result repeated after it was taken");

endmodule

@@ src/size_with_unit_parser_unit.sv @@
`timescale 1ns / 1ps
// size_with_unit_parser_unit: top level of the size string parser.
// Depends on swup_pkg, swup_trie and swup_scale.
//
//   channel  direction  ports                               word
//   req      in         req_valid req_stall req_ch           one character or
//                       req_end_mark                         the end marker
//   rsp      out        rsp_valid rsp_stall rsp_size_value   scaled size and
//                       rsp_status                           status
//
// One character is taken per cycle while req_stall is low; digits update the
// accumulator with a shift-add by ten and suffix characters step the matcher in
// that same cycle. An end marker's result leaves through the scaling pipeline
// (split 32 by 30 bit multiply, then a join and range check).
// Reset is synchronous and returns the parser to the start of a string.
// req_stall rises only while all three scaling stages hold results behind a
// stalled rsp channel.
module size_with_unit_parser_unit #(
   parameter int VALUE_BITS = 63
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [7:0]            req_ch,
   input  logic                  req_end_mark,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [VALUE_BITS-1:0] rsp_size_value,
   output logic [1:0]            rsp_status
);
   import swup_pkg::*;

   logic                  in_suffix_ff, in_suffix_in;
   logic [VALUE_BITS-1:0] acc_ff, acc_in;
   logic                  ovf_ff, ovf_in;
   trie_node_type         node_ff, node_in;

   logic                  req_fire, char_fire, end_fire;
   logic                  is_digit;
   logic [3:0]            digit;
   logic [VALUE_BITS+3:0] acc10;
   trie_node_type         node_next;
   unit_match_type        match;
   scale_ctl_type         scale_ctl;
   logic                  scale_ready;

   assign req_stall = !scale_ready;
   assign req_fire  = req_valid && !req_stall;
   assign char_fire = req_fire && !req_end_mark;
   assign end_fire  = req_fire && req_end_mark;

   // digits are ASCII 0x30 to 0x39, so the low nibble is the digit value
   assign is_digit = (req_ch >= CH_ZERO) && (req_ch <= CH_NINE);
   assign digit    = req_ch[3:0];

   // acc * 10 + digit as (acc << 3) + (acc << 1) + digit
   assign acc10 = {1'b0, acc_ff, 3'b000} + {3'b000, acc_ff, 1'b0}
                + (VALUE_BITS+4)'(digit);

   swup_trie u_trie (
      .node      (node_ff),
      .ch        (req_ch),
      .node_next (node_next),
      .match     (match)
   );

   // parser state update; the end marker returns to the start of a string
   always_comb begin
      in_suffix_in = in_suffix_ff;
      acc_in       = acc_ff;
      ovf_in       = ovf_ff;
      node_in      = node_ff;
      if (end_fire) begin
         in_suffix_in = 1'b0;
         acc_in       = '0;
         ovf_in       = 1'b0;
         node_in      = TRIE_ROOT;
      end else if (char_fire) begin
         if (!in_suffix_ff && is_digit) begin
            if (!ovf_ff) begin
               if (|acc10[VALUE_BITS+3:VALUE_BITS]) begin
                  ovf_in = 1'b1;
               end else begin
                  acc_in = acc10[VALUE_BITS-1:0];
               end
            end
         end else begin
            in_suffix_in = 1'b1;
            node_in      = node_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_suffix_ff <= 1'b0;
         acc_ff       <= '0;
         ovf_ff       <= 1'b0;
         node_ff      <= TRIE_ROOT;
      end else begin
         in_suffix_ff <= in_suffix_in;
         acc_ff       <= acc_in;
         ovf_ff       <= ovf_in;
         node_ff      <= node_in;
      end
   end

   // hand the finished number to the scaling pipeline
   assign scale_ctl.known      = match.known;
   assign scale_ctl.fam        = match.fam;
   assign scale_ctl.overflowed = ovf_ff;

   swup_scale #(
      .VALUE_BITS (VALUE_BITS)
   ) u_scale (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_valid && req_end_mark),
      .in_ready   (scale_ready),
      .in_acc     (acc_ff),
      .in_ctl     (scale_ctl),
      .out_valid  (rsp_valid),
      .out_stall  (rsp_stall),
      .out_value  (rsp_size_value),
      .out_status (rsp_status)
   );

   // an end marker leaves the parser at the start of a fresh string
   a_end_clears: assert property (@(posedge clock) disable iff (reset)
      end_fire |=> (!in_suffix_ff && acc_ff == '0 && !ovf_ff && node_ff == TRIE_ROOT))
      else $error("parser state not cleared after end marker");

   // a result that is not ok carries a zero size
   a_zero_unless_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != ST_OK) |-> (rsp_size_value == '0))
      else $error("non-zero size with error status");

   // the overflow flag holds until the string ends
   a_ovf_sticky: assert property (@(posedge clock) disable iff (reset)
      (ovf_ff && !end_fire) |=> ovf_ff)
      else $error("overflow flag dropped inside a string");

   // once in the suffix, digits no longer change the number
   a_suffix_freezes: assert property (@(posedge clock) disable iff (reset)
      (in_suffix_ff && !end_fire) |=> (in_suffix_ff && $stable(acc_ff)))
      else $error("number changed during the suffix");

endmodule
